### sv/hljsm_pkg.sv
// Package for the hash left join score merge block.
// Types, constants and arithmetic helpers; no dependencies.
`default_nettype none
package hljsm_pkg;
   localparam int TableDepthDefault = 1024;
   localparam logic [23:0] CountMax = 24'hFFFFFF;

   localparam logic [1:0] CsrOpMode = 2'd0;
   localparam logic [1:0] CsrSkip   = 2'd1;
   localparam logic [1:0] CsrLimit  = 2'd2;

   localparam logic [2:0] OpPlus  = 3'd0;
   localparam logic [2:0] OpMinus = 3'd1;
   localparam logic [2:0] OpMul   = 3'd2;
   localparam logic [2:0] OpLeft  = 3'd3;
   localparam logic [2:0] OpRight = 3'd4;

   localparam logic CmdLoad  = 1'b0;
   localparam logic CmdProbe = 1'b1;

   localparam logic [31:0] HashMult = 32'd2654435761;

   typedef struct packed {
      logic start;      // latch item, start hash multiply
      logic rd;         // issue memory read at probe position
      logic step;       // advance probe position
      logic wr;         // write current slot
      logic rsp_load;   // load output register
      logic clr_start;  // begin clearing pass
      logic clr_step;   // clear one entry
   } cmd_type;

   typedef struct packed {
      logic is_probe;
      logic last;
      logic hit;
      logic empty;
      logic wrapped;
      logic full;
      logic clr_done;
   } stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      begin
         if (v > 34'sd2147483647) r = 32'sh7FFFFFFF;
         else if (v < -34'sd2147483648) r = 32'sh80000000;
         else r = v[31:0];
         return r;
      end
   endfunction
endpackage
`default_nettype wire

### sv/hljsm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module hljsm_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wdata,
   output logic      [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

### sv/hljsm_ctrl.sv
// Controller state machine for the join block.
// Uses hljsm_pkg; drives hljsm_dp through cmd_type and reads stat_type.
`default_nettype none
module hljsm_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                rsp_free,
   input  wire hljsm_pkg::stat_type st,
   output hljsm_pkg::cmd_type       cmd
);
   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_HASH  = 7'b0000100,
      S_READ  = 7'b0001000,
      S_CHECK = 7'b0010000,
      S_OUT   = 7'b0100000,
      S_WAIT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_HASH;
            end
         end
         S_HASH: begin
            cmd.rd   = 1'b1;
            state_in = S_READ;
         end
         S_READ: state_in = S_CHECK;
         S_CHECK: begin
            if (st.hit || st.empty || st.wrapped) begin
               state_in = S_WAIT;
            end else begin
               cmd.step = 1'b1;
               state_in = S_HASH;
            end
         end
         S_WAIT: begin
            // multiply result settles here; wait for output register
            if (rsp_free) begin
               if (!st.is_probe) begin
                  if (st.hit || (st.empty && !st.full)) cmd.wr = 1'b1;
                  else cmd.rsp_load = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.rsp_load = 1'b1;
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (st.last) begin
               cmd.clr_start = 1'b1;
               state_in = S_CLEAR;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end
endmodule
`default_nettype wire

### sv/hljsm_dp.sv
// Datapath: hash, linear probe over table RAMs, score merge, output register.
// Uses hljsm_pkg and hljsm_ram; controlled by hljsm_ctrl.
`default_nettype none
module hljsm_dp #(
   parameter int TableDepth = hljsm_pkg::TableDepthDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hljsm_pkg::cmd_type  cmd,
   output hljsm_pkg::stat_type      st,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_index,
   input  wire logic [23:0]         csr_wdata,
   input  wire logic                req_cmd,
   input  wire logic [31:0]         req_row_id,
   input  wire logic signed [31:0]  req_score,
   input  wire logic                req_last,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_free,
   output logic                     rsp_status,
   output logic [31:0]              rsp_out_row_id,
   output logic signed [31:0]       rsp_out_score
);
   localparam int AW = $clog2(TableDepth);
   localparam int CW = $clog2(TableDepth + 1);

   logic [2:0]  op_ff;
   logic [23:0] skip_ff, limit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= hljsm_pkg::OpPlus;
         skip_ff  <= '0;
         limit_ff <= hljsm_pkg::CountMax;
      end else if (csr_we) begin
         case (csr_index)
            hljsm_pkg::CsrOpMode: op_ff    <= csr_wdata[2:0];
            hljsm_pkg::CsrSkip:   skip_ff  <= csr_wdata;
            hljsm_pkg::CsrLimit:  limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic                cmd_ff, last_ff;
   logic [31:0]         key_ff;
   logic signed [31:0]  score_ff;
   logic [31:0]         hprod_ff;
   logic [AW-1:0]       pos_ff, start_ff;
   logic                started_ff;
   logic [CW-1:0]       count_ff;
   logic [23:0]         idx_ff;
   logic [AW-1:0]       clr_ff;

   logic [31:0]        key_rd;
   logic signed [31:0] score_rd;
   logic [0:0]         valid_rd;
   logic [AW-1:0]      addr;
   logic               we;
   logic               valid_we;
   logic [0:0]         valid_wdata;
   logic [AW-1:0]      hpos;
   logic [AW-1:0]      rd_pos;

   // depth is a power of two, so the hash slot is the low product bits
   assign hpos   = hprod_ff[AW-1:0];
   assign rd_pos = started_ff ? pos_ff : hpos;

   assign we          = cmd.wr;
   assign valid_we    = cmd.wr | cmd.clr_step;
   assign valid_wdata = ~cmd.clr_step;
   assign addr        = cmd.clr_step ? clr_ff : rd_pos;

   hljsm_ram #(.Width(32), .Depth(TableDepth)) u_key (
      .clock(clock), .we(we), .addr(addr), .wdata(key_ff), .rdata(key_rd));
   hljsm_ram #(.Width(32), .Depth(TableDepth)) u_score (
      .clock(clock), .we(we), .addr(addr), .wdata(score_ff), .rdata(score_rd));
   hljsm_ram #(.Width(1), .Depth(TableDepth)) u_valid (
      .clock(clock), .we(valid_we), .addr(addr), .wdata(valid_wdata),
      .rdata(valid_rd));

   logic [AW-1:0] pos_nx;
   assign pos_nx = pos_ff + AW'(1);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cmd_ff   <= req_cmd;
         key_ff   <= req_row_id;
         score_ff <= req_score;
         last_ff  <= req_last;
         hprod_ff <= req_row_id * hljsm_pkg::HashMult;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         pos_ff     <= '0;
         start_ff   <= '0;
      end else if (cmd.start) begin
         started_ff <= 1'b0;
      end else if (cmd.rd && !started_ff) begin
         started_ff <= 1'b1;
         pos_ff     <= hpos;
         start_ff   <= hpos;
      end else if (cmd.step) begin
         pos_ff <= pos_nx;
      end
   end

   assign st.is_probe = cmd_ff;
   assign st.last     = last_ff;
   assign st.empty    = !valid_rd[0];
   assign st.hit      = valid_rd[0] && (key_rd == key_ff);
   assign st.wrapped  = (pos_nx == start_ff);
   assign st.full     = (count_ff == CW'(TableDepth));
   assign st.clr_done = (clr_ff == AW'(TableDepth - 1));

   // entry count, candidate index, clearing address
   always_ff @(posedge clock) begin
      if (reset || cmd.clr_start) begin
         count_ff <= '0;
         idx_ff   <= '0;
         clr_ff   <= '0;
      end else begin
         if (cmd.clr_step) clr_ff <= clr_ff + AW'(1);
         if (cmd.wr && !st.hit) count_ff <= count_ff + CW'(1);
         if (cmd.rsp_load && cmd_ff && idx_ff != hljsm_pkg::CountMax)
            idx_ff <= idx_ff + 24'd1;
      end
   end

   // merge: multiply registered in S_READ/S_CHECK timing
   logic signed [63:0] mprod_ff;
   always_ff @(posedge clock) mprod_ff <= score_ff * score_rd;

   logic signed [63:0] q;
   logic signed [47:0] qs;
   logic signed [31:0] mres, res;
   always_comb begin
      q  = mprod_ff + 64'sd32768;
      qs = q[63:16];
      if (qs > 48'sd2147483647) mres = 32'sh7FFFFFFF;
      else if (qs < -48'sd2147483648) mres = 32'sh80000000;
      else mres = qs[31:0];
      if (st.hit) begin
         case (op_ff)
            hljsm_pkg::OpPlus:
               res = hljsm_pkg::sat32(34'(score_ff) + 34'(score_rd));
            hljsm_pkg::OpMinus:
               res = hljsm_pkg::sat32(34'(score_ff) - 34'(score_rd));
            hljsm_pkg::OpMul:   res = mres;
            hljsm_pkg::OpLeft:  res = score_ff;
            hljsm_pkg::OpRight: res = score_rd;
            default:            res = '0;
         endcase
      end else begin
         res = (op_ff == hljsm_pkg::OpPlus || op_ff == hljsm_pkg::OpMinus ||
                op_ff == hljsm_pkg::OpLeft) ? score_ff : '0;
      end
   end

   logic [23:0] rel;
   logic        emit;
   assign rel  = idx_ff - skip_ff;
   assign emit = (idx_ff >= skip_ff) && (rel < limit_ff);

   logic vld_ff;
   assign rsp_valid = vld_ff;
   assign rsp_free  = !vld_ff || rsp_ready;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (cmd.rsp_load) vld_ff <= cmd_ff ? emit : 1'b1;
      else if (rsp_ready) vld_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status     <= !cmd_ff;
         rsp_out_row_id <= key_ff;
         rsp_out_score  <= cmd_ff ? res : '0;
      end
   end
endmodule
`default_nettype wire

### sv/hash_left_join_score_merge_top.sv
// Top level of the hash left join score merge block.
// Uses hljsm_pkg, hljsm_ctrl and hljsm_dp.
//  channel | ports                                     | dir
//  req     | req_valid/ready, cmd,row_id,score,last    | in
//  rsp     | rsp_valid/ready, status,out_row_id,score  | out
//  csr     | csr_we, csr_index, csr_wdata              | in
// A load steps S_IDLE, S_HASH, S_READ, S_CHECK, S_WAIT; a probe adds
// S_OUT; each extra probe slot repeats S_HASH to S_CHECK. TableDepth
// must be a power of two. After reset and after a probe with last, a
// clearing pass over all entries runs before the next item is taken.
// A stalled result holds the block in S_WAIT until rsp_free is set.
`default_nettype none
module hash_left_join_score_merge_top #(
   parameter int TableDepth = hljsm_pkg::TableDepthDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_cmd,
   input  wire logic [31:0]        req_row_id,
   input  wire logic signed [31:0] req_score,
   input  wire logic               req_last,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_status,
   output logic [31:0]             rsp_out_row_id,
   output logic signed [31:0]      rsp_out_score,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [23:0]        csr_wdata
);
   hljsm_pkg::cmd_type  cmd;
   hljsm_pkg::stat_type st;
   logic rsp_free;

   hljsm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_free(rsp_free), .st(st), .cmd(cmd));

   hljsm_dp #(.TableDepth(TableDepth)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .st(st),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_cmd(req_cmd), .req_row_id(req_row_id), .req_score(req_score),
      .req_last(req_last), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_free(rsp_free), .rsp_status(rsp_status),
      .rsp_out_row_id(rsp_out_row_id), .rsp_out_score(rsp_out_score));
endmodule
`default_nettype wire
